// ===== rtl/pwm_controller_16ch_regs_unit_defines.svh =====
// Assertion macros shared by the checker of the PWM controller.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PWM_CONTROLLER_16CH_REGS_UNIT_DEFINES_SVH
`define PWM_CONTROLLER_16CH_REGS_UNIT_DEFINES_SVH

// Antecedent on this edge implies consequent on the next edge.
`define PWMC16R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property failed");

// Antecedent implies consequent on the same edge.
`define PWMC16R_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property failed");

`endif

// ===== rtl/pwmc16r_pkg.sv =====
// Package of the PWM controller: sizes, register map, reset values and codes.
// No dependencies; used by the interfaces, the top level and the checker.
package pwmc16r_pkg;

   // Sizes
   localparam int NUM_CHANNELS = 16;
   localparam int COUNT_BITS   = 12;
   localparam int CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PWM_BITS     = 16;
   localparam int HI_BITS      = 5;

   // Register map
   localparam logic [7:0] MODE_ONE_ADDR  = 8'h00;
   localparam logic [7:0] MODE_TWO_ADDR  = 8'h01;
   localparam logic [7:0] SUB_ADDR_FIRST = 8'h02;
   localparam logic [7:0] SUB_ADDR_LAST  = 8'h05;
   localparam logic [7:0] CH_BASE        = 8'h06;
   localparam logic [7:0] CH_END         = 8'(6 + 4 * NUM_CHANNELS);
   localparam logic [7:0] ALL_BASE       = 8'hFA;
   localparam logic [7:0] ALL_LAST       = 8'hFD;
   localparam logic [7:0] PRESCALE_ADDR  = 8'hFE;

   // Bit positions
   localparam int SLEEP_BIT  = 4;
   localparam int INVERT_BIT = 4;
   localparam int FULL_BIT   = 4;

   localparam logic [7:0] MIN_PRESCALE = 8'd3;

   // Reset values
   localparam logic [7:0]         MODE_ONE_RESET = 8'h11;
   localparam logic [HI_BITS-1:0] MODE_TWO_RESET = 5'h04;
   localparam logic [7:0]         PRESCALE_RESET = 8'd30;
   localparam logic [HI_BITS-1:0] OFF_HI_RESET   = 5'h10;
   localparam logic [3:0][7:0]    SUB_ADDR_RESET = {8'hE0, 8'hE8, 8'hE4, 8'hE2};

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   // Byte within a channel's group of four
   typedef enum logic [1:0] {
      BYTE_ON_LO  = 2'd0,
      BYTE_ON_HI  = 2'd1,
      BYTE_OFF_LO = 2'd2,
      BYTE_OFF_HI = 2'd3
   } byte_sel_type;

   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [CH_IDX_BITS-1:0] ch_idx_type;
   typedef logic [HI_BITS-1:0]     hi_byte_type;

endpackage

// ===== rtl/pwmc16r_req_if.sv =====
// Request channel of the PWM controller: valid/ready plus one bus word.
// Depends on pwmc16r_pkg.
interface pwmc16r_req_if;
   logic                  valid;
   logic                  ready;
   pwmc16r_pkg::func_type func;
   logic [7:0]            reg_addr;
   logic [7:0]            write_data;

   modport source (output valid, output func, output reg_addr, output write_data,
                   input ready);
   modport sink   (input valid, input func, input reg_addr, input write_data,
                   output ready);
endinterface

// ===== rtl/pwmc16r_rsp_if.sv =====
// Response channel of the PWM controller: valid/ready plus one result word.
// Depends on pwmc16r_pkg.
interface pwmc16r_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [7:0]                       read_data;
   logic [pwmc16r_pkg::PWM_BITS-1:0] pwm_out;
   logic                             period_start;

   modport source (output valid, output read_data, output pwm_out,
                   output period_start, input ready);
   modport sink   (input valid, input read_data, input pwm_out,
                   input period_start, output ready);
endinterface

// ===== rtl/pwm_controller_16ch_regs_unit.sv =====
// Sixteen-channel PWM generator with a byte register map.
// Depends on pwmc16r_pkg, pwmc16r_req_if and pwmc16r_rsp_if.
//
// Usage:
//   req_chan carries one word per step: a clock tick, a register write or a
//   register read (func, reg_addr, write_data). rsp_chan returns exactly one
//   word per request: the read byte (zero unless a read), the channel levels
//   after the step and a flag for the period counter wrapping to zero.
//   A word accepted at one edge is shown on rsp_chan after that edge.
//   Throughput is one word per cycle while the receiver takes results;
//   the register file, the prescale divider, the period counter and the
//   sixteen compares are all updated in the accepting cycle.
//   The result sits in an output register; req_chan stays ready while that
//   register is empty or being taken in the same cycle, so a stalled
//   receiver holds the result stable and stalls the requester after it.
//   Synchronous reset restores the register map defaults (asleep, all
//   channels fully off, prescale 30), clears the counters and empties the
//   output register. No clearing pass is needed.
module pwm_controller_16ch_regs_unit (
   input  logic                 clock,
   input  logic                 reset,
   pwmc16r_req_if.sink          req_chan,
   pwmc16r_rsp_if.source        rsp_chan
);

   localparam int NCH = pwmc16r_pkg::NUM_CHANNELS;

   // State registers
   logic [7:0]                     mode_one_ff, mode_one_in;
   pwmc16r_pkg::hi_byte_type       mode_two_ff, mode_two_in;
   logic [3:0][7:0]                sub_addr_ff, sub_addr_in;
   logic [7:0]                     on_lo_ff  [NCH];
   logic [7:0]                     on_lo_in  [NCH];
   pwmc16r_pkg::hi_byte_type       on_hi_ff  [NCH];
   pwmc16r_pkg::hi_byte_type       on_hi_in  [NCH];
   logic [7:0]                     off_lo_ff [NCH];
   logic [7:0]                     off_lo_in [NCH];
   pwmc16r_pkg::hi_byte_type       off_hi_ff [NCH];
   pwmc16r_pkg::hi_byte_type       off_hi_in [NCH];
   logic [7:0]                     prescale_ff, prescale_in;
   logic [7:0]                     divider_ff, divider_in;
   pwmc16r_pkg::count_type         period_ff, period_in;

   // Output register
   logic                           rsp_valid_ff;
   logic [7:0]                     read_data_ff, read_data_in;
   logic [pwmc16r_pkg::PWM_BITS-1:0] pwm_out_ff, pwm_out_in;
   logic                           start_ff, start_in;

   // Decode
   logic                           accept;
   logic                           is_ch, is_all, chan_wr;
   logic [7:0]                     ch_off;
   pwmc16r_pkg::ch_idx_type        ch_sel;
   pwmc16r_pkg::byte_sel_type      byte_sel, all_sel, wr_sel;
   logic [7:0]                     wdata;
   logic [NCH-1:0]                 levels;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign wdata          = req_chan.write_data;

   // Address decode
   always_comb begin
      is_ch    = (req_chan.reg_addr >= pwmc16r_pkg::CH_BASE) &&
                 (req_chan.reg_addr <  pwmc16r_pkg::CH_END);
      is_all   = (req_chan.reg_addr >= pwmc16r_pkg::ALL_BASE) &&
                 (req_chan.reg_addr <= pwmc16r_pkg::ALL_LAST);
      ch_off   = req_chan.reg_addr - pwmc16r_pkg::CH_BASE;
      ch_sel   = ch_off[2 +: pwmc16r_pkg::CH_IDX_BITS];
      byte_sel = pwmc16r_pkg::byte_sel_type'(ch_off[1:0]);
      all_sel  = pwmc16r_pkg::byte_sel_type'(2'(req_chan.reg_addr - pwmc16r_pkg::ALL_BASE));
      wr_sel   = is_all ? all_sel : byte_sel;
      chan_wr  = accept && (req_chan.func == pwmc16r_pkg::FUNC_WRITE) && (is_ch || is_all);
   end

   // Next state and read data
   always_comb begin
      mode_one_in  = mode_one_ff;
      mode_two_in  = mode_two_ff;
      sub_addr_in  = sub_addr_ff;
      prescale_in  = prescale_ff;
      divider_in   = divider_ff;
      period_in    = period_ff;
      read_data_in = 8'd0;
      start_in     = 1'b0;

      if (accept) begin
         unique case (req_chan.func)
            pwmc16r_pkg::FUNC_TICK: begin
               // Counters hold while asleep
               if (!mode_one_ff[pwmc16r_pkg::SLEEP_BIT]) begin
                  if (divider_ff >= prescale_ff) begin
                     divider_in = 8'd0;
                     period_in  = period_ff + 1'b1;
                     start_in   = (period_in == '0);
                  end else begin
                     divider_in = divider_ff + 8'd1;
                  end
               end
            end
            pwmc16r_pkg::FUNC_WRITE: begin
               priority if (req_chan.reg_addr == pwmc16r_pkg::MODE_ONE_ADDR) begin
                  mode_one_in = wdata;
               end else if (req_chan.reg_addr == pwmc16r_pkg::MODE_TWO_ADDR) begin
                  mode_two_in = wdata[pwmc16r_pkg::HI_BITS-1:0];
               end else if (req_chan.reg_addr >= pwmc16r_pkg::SUB_ADDR_FIRST &&
                            req_chan.reg_addr <= pwmc16r_pkg::SUB_ADDR_LAST) begin
                  sub_addr_in[2'(req_chan.reg_addr - pwmc16r_pkg::SUB_ADDR_FIRST)] = wdata;
               end else if (req_chan.reg_addr == pwmc16r_pkg::PRESCALE_ADDR) begin
                  // Prescale only takes while asleep; clamp small values
                  if (mode_one_ff[pwmc16r_pkg::SLEEP_BIT]) begin
                     prescale_in = (wdata < pwmc16r_pkg::MIN_PRESCALE) ?
                                   pwmc16r_pkg::MIN_PRESCALE : wdata;
                  end
               end else begin
                  // channel and broadcast bytes handled below; rest ignored
               end
            end
            pwmc16r_pkg::FUNC_READ: begin
               priority if (req_chan.reg_addr == pwmc16r_pkg::MODE_ONE_ADDR) begin
                  read_data_in = mode_one_ff;
               end else if (req_chan.reg_addr == pwmc16r_pkg::MODE_TWO_ADDR) begin
                  read_data_in = {3'b000, mode_two_ff};
               end else if (req_chan.reg_addr >= pwmc16r_pkg::SUB_ADDR_FIRST &&
                            req_chan.reg_addr <= pwmc16r_pkg::SUB_ADDR_LAST) begin
                  read_data_in = sub_addr_ff[2'(req_chan.reg_addr - pwmc16r_pkg::SUB_ADDR_FIRST)];
               end else if (is_ch) begin
                  unique case (byte_sel)
                     pwmc16r_pkg::BYTE_ON_LO:  read_data_in = on_lo_ff[ch_sel];
                     pwmc16r_pkg::BYTE_ON_HI:  read_data_in = {3'b000, on_hi_ff[ch_sel]};
                     pwmc16r_pkg::BYTE_OFF_LO: read_data_in = off_lo_ff[ch_sel];
                     pwmc16r_pkg::BYTE_OFF_HI: read_data_in = {3'b000, off_hi_ff[ch_sel]};
                     default:                  read_data_in = 8'd0;
                  endcase
               end else if (req_chan.reg_addr == pwmc16r_pkg::PRESCALE_ADDR) begin
                  read_data_in = prescale_ff;
               end else begin
                  read_data_in = 8'd0;
               end
            end
            pwmc16r_pkg::FUNC_NOP: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Channel byte writes, single channel or broadcast
   always_comb begin
      for (int ch = 0; ch < NCH; ch++) begin
         on_lo_in[ch]  = on_lo_ff[ch];
         on_hi_in[ch]  = on_hi_ff[ch];
         off_lo_in[ch] = off_lo_ff[ch];
         off_hi_in[ch] = off_hi_ff[ch];
         if (chan_wr && (is_all || ch_sel == pwmc16r_pkg::ch_idx_type'(ch))) begin
            unique case (wr_sel)
               pwmc16r_pkg::BYTE_ON_LO:  on_lo_in[ch]  = wdata;
               pwmc16r_pkg::BYTE_ON_HI:  on_hi_in[ch]  = wdata[pwmc16r_pkg::HI_BITS-1:0];
               pwmc16r_pkg::BYTE_OFF_LO: off_lo_in[ch] = wdata;
               pwmc16r_pkg::BYTE_OFF_HI: off_hi_in[ch] = wdata[pwmc16r_pkg::HI_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Channel levels from the post-step state
   always_comb begin
      pwmc16r_pkg::count_type on_c;
      pwmc16r_pkg::count_type off_c;
      logic                   normal;
      on_c   = '0;
      off_c  = '0;
      normal = 1'b0;
      for (int ch = 0; ch < NCH; ch++) begin
         on_c  = pwmc16r_pkg::count_type'({on_hi_in[ch][3:0], on_lo_in[ch]});
         off_c = pwmc16r_pkg::count_type'({off_hi_in[ch][3:0], off_lo_in[ch]});
         if (on_c < off_c) begin
            normal = (period_in >= on_c) && (period_in < off_c);
         end else if (on_c > off_c) begin
            normal = (period_in >= on_c) || (period_in < off_c);
         end else begin
            normal = 1'b0;
         end
         levels[ch] = !mode_one_in[pwmc16r_pkg::SLEEP_BIT] &&
                      !off_hi_in[ch][pwmc16r_pkg::FULL_BIT] &&
                      (on_hi_in[ch][pwmc16r_pkg::FULL_BIT] || normal);
      end
      pwm_out_in = pwmc16r_pkg::PWM_BITS'(levels ^ {NCH{mode_two_in[pwmc16r_pkg::INVERT_BIT]}});
   end

   // State update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_one_ff <= pwmc16r_pkg::MODE_ONE_RESET;
         mode_two_ff <= pwmc16r_pkg::MODE_TWO_RESET;
         sub_addr_ff <= pwmc16r_pkg::SUB_ADDR_RESET;
         prescale_ff <= pwmc16r_pkg::PRESCALE_RESET;
         divider_ff  <= 8'd0;
         period_ff   <= '0;
         for (int ch = 0; ch < NCH; ch++) begin
            on_lo_ff[ch]  <= 8'd0;
            on_hi_ff[ch]  <= '0;
            off_lo_ff[ch] <= 8'd0;
            off_hi_ff[ch] <= pwmc16r_pkg::OFF_HI_RESET;
         end
      end else begin
         mode_one_ff <= mode_one_in;
         mode_two_ff <= mode_two_in;
         sub_addr_ff <= sub_addr_in;
         prescale_ff <= prescale_in;
         divider_ff  <= divider_in;
         period_ff   <= period_in;
         for (int ch = 0; ch < NCH; ch++) begin
            on_lo_ff[ch]  <= on_lo_in[ch];
            on_hi_ff[ch]  <= on_hi_in[ch];
            off_lo_ff[ch] <= off_lo_in[ch];
            off_hi_ff[ch] <= off_hi_in[ch];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= read_data_in;
         pwm_out_ff   <= pwm_out_in;
         start_ff     <= start_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = read_data_ff;
   assign rsp_chan.pwm_out      = pwm_out_ff;
   assign rsp_chan.period_start = start_ff;

endmodule

// ===== rtl/pwmc16r_checker.sv =====
// Port-level checker for the PWM controller, bound to the top level.
// Depends on pwmc16r_pkg and pwm_controller_16ch_regs_unit_defines.svh.
`include "pwm_controller_16ch_regs_unit_defines.svh"

module pwmc16r_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input pwmc16r_pkg::func_type            req_func,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [7:0]                       rsp_read_data,
   input logic [pwmc16r_pkg::PWM_BITS-1:0] rsp_pwm_out,
   input logic                             rsp_period_start
);

   logic                             req_acc;
   logic                             rsp_stall;
   logic                             non_read_acc;
   logic                             non_tick_acc;
   logic [pwmc16r_pkg::PWM_BITS+8:0] rsp_word;

   assign req_acc      = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign non_read_acc = req_acc && (req_func != pwmc16r_pkg::FUNC_READ);
   assign non_tick_acc = req_acc && (req_func != pwmc16r_pkg::FUNC_TICK);
   assign rsp_word     = {rsp_read_data, rsp_pwm_out, rsp_period_start};

   // A stalled result word holds
   `PWMC16R_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))
   // Every accepted word shows a result on the next cycle
   `PWMC16R_ASSERT_NEXT(a_one_cycle, clock, reset, req_acc, rsp_valid)
   // Only reads return data
   `PWMC16R_ASSERT_NEXT(a_read_only, clock, reset, non_read_acc, rsp_read_data == 8'd0)
   // Only ticks may wrap the period
   `PWMC16R_ASSERT_NEXT(a_tick_only, clock, reset, non_tick_acc, !rsp_period_start)
   // Reset empties the output register
   `PWMC16R_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind pwm_controller_16ch_regs_unit pwmc16r_checker u_pwmc16r_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_func         (req_chan.func),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_read_data    (rsp_chan.read_data),
   .rsp_pwm_out      (rsp_chan.pwm_out),
   .rsp_period_start (rsp_chan.period_start)
);
